[rtl/core/pfma_pkg.sv]
// ----------------------------------------------------------------------------
// Prime field modular ALU package
// Shared operation codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pfma_pkg;

    // Operation codes carried by the mode field.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,     // latch operands, modulus, mode
        DP_REDUCE,   // one restoring step of a %= p and b %= p
        DP_ADDSUB,   // finish add or subtract
        DP_MUL_INIT, // start a bit-serial multiply
        DP_MUL_STEP, // one double-and-add step
        DP_POW_INIT, // start the exponent scan
        DP_POW_END   // step to the next exponent bit
    } dp_op_t;

    // Multiply source selection.
    typedef enum logic [1:0] {
        MS_SQUARE,   // acc * acc
        MS_BASE,     // acc * base
        MS_FINAL_AB  // a * b for a plain multiply, a * acc for the divide finish
    } mul_src_t;

    typedef struct packed {
        dp_op_t   op;
        mul_src_t src;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;   // multiply holds its last step
        logic red_done;   // reduction finished
        logic exp_bit;    // current exponent bit
        logic exp_last;   // current exponent bit is bit 0
        logic p_small;    // modulus below two
        logic b_zero;     // reduced b is zero
    } dp_stat_t;

endpackage

[rtl/core/prime_field_modular_alu.sv]
// ----------------------------------------------------------------------------
// Prime field modular ALU top level
// Multiply, power and divide use the bit-serial multiplier, which power and
// divide run once or twice per exponent bit. One transaction at a time; the
// next is accepted only after the result has been taken.
// Reset (synchronous, active low): modulus 2, previous result and count zero.
// ----------------------------------------------------------------------------
module prime_field_modular_alu
    import pfma_pkg::*;
#(
    parameter int FIELD_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [63:0] s_operand_a,
    input  logic [63:0] s_operand_b,
    input  logic        s_a_is_previous,
    input  logic        s_b_is_previous,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result,
    output logic [31:0] m_result_number
);

    localparam int W = FIELD_WIDTH;

    logic [W-1:0] p_reg, prev_reg, res_value, acc_out, a_in, b_in, base_in;
    logic [31:0]  cnt_reg;
    logic         m_valid_i, s_ready_i;
    logic         commit_q, m_valid_q;
    dp_cmd_t      cmd;
    dp_stat_t     stat;

    assign a_in    = s_a_is_previous ? prev_reg : s_operand_a[W-1:0];
    assign b_in    = s_b_is_previous ? prev_reg : s_operand_b[W-1:0];
    assign base_in = b_in;

    // Modulus register, previous result and result count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg    <= W'(2);
            prev_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (cfg_we) p_reg <= cfg_wdata[W-1:0];
            if (commit_q) begin
                prev_reg <= res_value;
                cnt_reg  <= cnt_reg + 32'd1;
            end
        end
    end

    assign commit_q = m_valid_i && !m_valid_q;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_q <= 1'b0;
        else          m_valid_q <= m_valid_i;
    end

    pfma_datapath #(.W(W)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_a(a_in), .in_b(base_in), .in_p(p_reg),
        .in_div(s_mode == OP_DIV), .acc_out
    );

    pfma_ctrl #(.W(W)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready(s_ready_i), .s_mode,
        .m_valid(m_valid_i), .m_ready, .cmd, .stat, .acc_out, .res_value
    );

    assign s_ready         = s_ready_i;
    assign m_valid         = m_valid_i;
    assign m_result        = 64'(res_value);
    assign m_result_number = cnt_reg + (commit_q ? 32'd1 : 32'd0);

    // No transaction is taken while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("input accepted with result pending");
    // The result holds while stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result))
        else $error("result changed under stall");
    // A delivered result is below the modulus when the modulus is valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (p_reg >= W'(2)) |-> (res_value < p_reg))
        else $error("result not reduced");

endmodule

[rtl/core/pfma_datapath.sv]
// ----------------------------------------------------------------------------
// Prime field modular ALU datapath
// Operand registers, a bit-serial reducer and a bit-serial modular multiplier
// driven by the controller one step per cycle.
// ----------------------------------------------------------------------------
module pfma_datapath
    import pfma_pkg::*;
#(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  dp_cmd_t      cmd,
    output dp_stat_t     stat,
    input  logic [W-1:0] in_a,
    input  logic [W-1:0] in_b,
    input  logic [W-1:0] in_p,
    input  logic         in_div,
    output logic [W-1:0] acc_out
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  a_reg, b_reg, e_reg, p_reg, base_reg, acc_reg, x_reg, y_reg;
    logic [W-1:0]  mr_reg;
    logic [CW-1:0] cnt_reg, ecnt_reg;
    logic [W:0]    ra_reg, rb_reg;
    logic          div_reg;
    logic [W-1:0]  dbl, sum;
    logic [W:0]    dbl_w, sum_w, ra_t, rb_t;

    // Modular doubling and addition for one multiply step.
    always_comb begin
        dbl_w = {1'b0, mr_reg} + {1'b0, mr_reg};
        dbl   = (dbl_w >= {1'b0, p_reg}) ? W'(dbl_w - {1'b0, p_reg}) : dbl_w[W-1:0];
        sum_w = {1'b0, dbl} + {1'b0, x_reg};
        sum   = (sum_w >= {1'b0, p_reg}) ? W'(sum_w - {1'b0, p_reg}) : sum_w[W-1:0];
        // Restoring reduction step: shift in next bit of the raw operand.
        ra_t  = {ra_reg[W-1:0], a_reg[W-1]};
        rb_t  = {rb_reg[W-1:0], b_reg[W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ecnt_reg <= '0;
        end else begin
            unique case (cmd.op)
                DP_LOAD: begin
                    a_reg   <= in_a;
                    b_reg   <= in_b;
                    e_reg   <= in_div ? W'(in_p - W'(2)) : in_b;
                    p_reg   <= in_p;
                    div_reg <= in_div;
                    ra_reg  <= '0;
                    rb_reg  <= '0;
                    cnt_reg <= CW'(W - 1);
                end
                DP_REDUCE: begin
                    a_reg  <= a_reg << 1;
                    b_reg  <= b_reg << 1;
                    ra_reg <= (ra_t >= {1'b0, p_reg}) ? ra_t - {1'b0, p_reg} : ra_t;
                    rb_reg <= (rb_t >= {1'b0, p_reg}) ? rb_t - {1'b0, p_reg} : rb_t;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                DP_ADDSUB: begin
                    acc_reg <= '0;
                end
                DP_POW_INIT: begin
                    base_reg <= div_reg ? rb_reg[W-1:0] : ra_reg[W-1:0];
                    acc_reg  <= W'(1);
                    ecnt_reg <= CW'(W - 1);
                end
                DP_MUL_INIT: begin
                    mr_reg  <= '0;
                    cnt_reg <= CW'(W - 1);
                    unique case (cmd.src)
                        MS_SQUARE:   begin x_reg <= acc_reg;       y_reg <= acc_reg; end
                        MS_BASE:     begin x_reg <= base_reg;      y_reg <= acc_reg; end
                        default:     begin
                            x_reg <= ra_reg[W-1:0];
                            y_reg <= div_reg ? acc_reg : rb_reg[W-1:0];
                        end
                    endcase
                end
                DP_MUL_STEP: begin
                    mr_reg  <= y_reg[W-1] ? sum : dbl;
                    y_reg   <= y_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        acc_reg <= y_reg[W-1] ? sum : dbl;
                    end
                end
                DP_POW_END: begin
                    e_reg    <= e_reg << 1;
                    ecnt_reg <= ecnt_reg - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Add/subtract result formed from the reduced operands.
    logic [W:0] as_sum;
    assign as_sum = {1'b0, ra_reg[W-1:0]} + {1'b0, rb_reg[W-1:0]};

    assign stat.mul_done = (cnt_reg == '0);
    assign stat.red_done = (cnt_reg == '0);
    assign stat.exp_bit  = e_reg[W-1];
    assign stat.exp_last = (ecnt_reg == '0);
    assign stat.p_small  = (p_reg < W'(2));
    assign stat.b_zero   = (rb_reg == '0);

    // Final selection of add/sub is made here in acc_out, chosen by the command source.
    logic [W:0] sub_w;
    assign sub_w   = {1'b0, ra_reg[W-1:0]} - {1'b0, rb_reg[W-1:0]};
    assign acc_out = (cmd.src == MS_SQUARE && cmd.op == DP_ADDSUB) ?
                     ((as_sum >= {1'b0, p_reg}) ? W'(as_sum - {1'b0, p_reg}) : as_sum[W-1:0]) :
                     (cmd.src == MS_BASE && cmd.op == DP_ADDSUB) ?
                     (sub_w[W] ? W'(sub_w + {1'b0, p_reg}) : sub_w[W-1:0]) :
                     acc_reg;

endmodule

[rtl/core/pfma_ctrl.sv]
// ----------------------------------------------------------------------------
// Prime field modular ALU controller
// Sequences reduction, add/subtract, multiply and the square-and-multiply
// exponent scan, and runs the input/output handshake.
// ----------------------------------------------------------------------------
module pfma_ctrl
    import pfma_pkg::*;
#(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_mode,
    output logic         m_valid,
    input  logic         m_ready,
    output dp_cmd_t      cmd,
    input  dp_stat_t     stat,
    input  logic [W-1:0] acc_out,
    output logic [W-1:0] res_value
);

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_DISPATCH, S_MUL, S_SQ, S_SQ_RUN, S_BASE, S_BASE_RUN,
        S_EBIT, S_FMUL, S_FMUL_RUN, S_DONE
    } state_t;

    state_t     state_reg;
    logic [2:0] mode_reg;
    logic       m_valid_reg;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    // Command decode from state.
    always_comb begin
        cmd.op  = DP_NOP;
        cmd.src = MS_FINAL_AB;
        unique case (state_reg)
            S_IDLE:     if (s_valid && s_ready && s_mode <= OP_POW) cmd.op = DP_LOAD;
            S_RED:      cmd.op = DP_REDUCE;
            S_DISPATCH: begin
                if (mode_reg == OP_ADD || mode_reg == OP_SUB) begin
                    cmd.op  = DP_ADDSUB;
                    cmd.src = (mode_reg == OP_ADD) ? MS_SQUARE : MS_BASE;
                end else if (mode_reg == OP_MUL) begin
                    cmd.op = DP_MUL_INIT;
                end else begin
                    cmd.op = DP_POW_INIT;
                end
            end
            S_SQ:       begin cmd.op = DP_MUL_INIT; cmd.src = MS_SQUARE; end
            S_BASE:     begin cmd.op = DP_MUL_INIT; cmd.src = MS_BASE; end
            S_FMUL:     cmd.op = DP_MUL_INIT;
            S_MUL, S_SQ_RUN, S_BASE_RUN, S_FMUL_RUN: cmd.op = DP_MUL_STEP;
            S_EBIT:     cmd.op = DP_POW_END;
            default:    ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            mode_reg    <= OP_ADD;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready && s_mode <= OP_POW) begin
                    mode_reg  <= s_mode;
                    state_reg <= S_RED;
                end
                S_RED: if (stat.red_done) state_reg <= S_DISPATCH;
                S_DISPATCH: begin
                    if (stat.p_small) begin
                        res_value <= '0;
                        state_reg <= S_DONE;
                    end else if (mode_reg == OP_ADD || mode_reg == OP_SUB) begin
                        res_value <= acc_out;
                        state_reg <= S_DONE;
                    end else if (mode_reg == OP_MUL) begin
                        state_reg <= S_MUL;
                    end else if (mode_reg == OP_DIV && stat.b_zero) begin
                        res_value <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_SQ;
                    end
                end
                S_MUL, S_FMUL_RUN: if (stat.mul_done) state_reg <= S_DONE;
                S_SQ:      state_reg <= S_SQ_RUN;
                S_SQ_RUN:  if (stat.mul_done) state_reg <= stat.exp_bit ? S_BASE : S_EBIT;
                S_BASE:    state_reg <= S_BASE_RUN;
                S_BASE_RUN: if (stat.mul_done) state_reg <= S_EBIT;
                S_EBIT: begin
                    if (!stat.exp_last) begin
                        state_reg <= S_SQ;
                    end else if (mode_reg == OP_DIV) begin
                        state_reg <= S_FMUL;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_FMUL: state_reg <= S_FMUL_RUN;
                S_DONE: begin
                    if (mode_reg == OP_MUL || mode_reg == OP_DIV || mode_reg == OP_POW) begin
                        if (!stat.p_small && !(mode_reg == OP_DIV && stat.b_zero))
                            res_value <= acc_out;
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
